/* rtl/voltage_battery_capacity_tracker_core_defines.svh */
// Assertion macros used by the capacity tracker back end.
// They expect clk_i and rst_ni to exist in the module that uses them.
`ifndef VOLTAGE_BATTERY_CAPACITY_TRACKER_CORE_DEFINES_SVH
`define VOLTAGE_BATTERY_CAPACITY_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTH

`define VBCT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define VBCT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define VBCT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VBCT_ASSERT(name, prop, msg)
`define VBCT_ASSERT_IMP(name, ante, cons, msg)
`define VBCT_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

/* rtl/vbct_pkg.sv */
package vbct_pkg;

  localparam int unsigned PCT_W     = 7;
  localparam int unsigned GAP_W     = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned DIV_STEPS = 7;
  // Scaled numerator: a 16 bit difference times one hundred.
  localparam int unsigned NUM_W     = CFG_W + PCT_W;
  localparam int unsigned STEP_W    = 3;

  localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

  localparam logic CFG_EMPTY = 1'b0;
  localparam logic CFG_FULL  = 1'b1;

  typedef enum logic [1:0] {
    OP_UPDATE     = 2'd0,
    OP_UNRELIABLE = 2'd1,
    OP_DEFAULTS   = 2'd2,
    OP_SUSPEND    = 2'd3
  } op_e;

  // A classified item as it sits in the queue between front and back.
  typedef struct packed {
    op_e              op;
    logic             mode;
    logic             is_zero;
    logic             is_sat;
    logic [CFG_W-1:0] diff;
    logic [CFG_W-1:0] den;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] diff;
    logic [CFG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/vbct_front.sv */
module vbct_front #(
  parameter int unsigned VOLTAGE_BITS = 16
) (
  input  logic                       push_i,
  input  logic                       q_full_i,
  input  logic [1:0]                 operation_i,
  input  logic [VOLTAGE_BITS-1:0]    voltage_sample_i,
  input  logic                       relative_mode_i,
  input  logic [vbct_pkg::CFG_W-1:0] empty_voltage_i,
  input  logic [vbct_pkg::CFG_W-1:0] full_voltage_i,
  output logic                       wr_en_o,
  output vbct_pkg::item_t            item_o
);

  localparam int unsigned CMP_W = (VOLTAGE_BITS > vbct_pkg::CFG_W) ? VOLTAGE_BITS
                                                                    : vbct_pkg::CFG_W;

  logic [CMP_W-1:0] v_ext;
  logic [CMP_W-1:0] lo_ext;
  logic [CMP_W-1:0] hi_ext;
  logic             below;

  assign v_ext  = CMP_W'(voltage_sample_i);
  assign lo_ext = CMP_W'(empty_voltage_i);
  assign hi_ext = CMP_W'(full_voltage_i);
  assign below  = v_ext <= lo_ext;

  assign wr_en_o = push_i && !q_full_i;

  // The difference is only used when the sample lies strictly between the
  // two limits, so it always fits the register width.
  always_comb begin
    item_o.op      = vbct_pkg::op_e'(operation_i);
    item_o.mode    = relative_mode_i;
    item_o.is_zero = below;
    item_o.is_sat  = !below && (v_ext >= hi_ext);
    item_o.diff    = v_ext[vbct_pkg::CFG_W-1:0] - empty_voltage_i;
    item_o.den     = full_voltage_i - empty_voltage_i;
  end

endmodule

/* rtl/vbct_queue.sv */
module vbct_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  vbct_pkg::item_t wr_item_i,
  input  logic            rd_en_i,
  output vbct_pkg::item_t rd_item_o,
  output logic            full_o,
  output logic            empty_o
);

  vbct_pkg::item_t entry_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  assign full_o    = count_q == 2'd2;
  assign empty_o   = count_q == 2'd0;
  assign rd_item_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (rd_en_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 2'd1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

/* rtl/vbct_div.sv */
module vbct_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vbct_pkg::div_req_t req_i,
  output vbct_pkg::div_rsp_t rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [vbct_pkg::STEP_W-1:0]    step_q, step_d;
  logic [vbct_pkg::NUM_W-1:0]     rem_q, rem_d;
  logic [vbct_pkg::CFG_W-1:0]     den_q, den_d;
  logic [vbct_pkg::PCT_W-1:0]     quo_q, quo_d;
  logic [vbct_pkg::NUM_W-1:0]     shifted;

  assign shifted = vbct_pkg::NUM_W'(den_q) << step_q;

  // Restoring division, one quotient bit per cycle, top bit first. The
  // quotient is known to stay below one hundred.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = vbct_pkg::STEP_W'(vbct_pkg::DIV_STEPS - 1);
      rem_d  = vbct_pkg::NUM_W'(req_i.diff) * vbct_pkg::NUM_W'(vbct_pkg::FULL_PERCENT);
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_q >= shifted) begin
        rem_d         = rem_q - shifted;
        quo_d[step_q] = 1'b1;
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - vbct_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* rtl/vbct_back.sv */
`include "voltage_battery_capacity_tracker_core_defines.svh"

module vbct_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  vbct_pkg::item_t            q_item_i,
  output logic                       q_pop_o,
  output vbct_pkg::div_req_t         div_req_o,
  input  vbct_pkg::div_rsp_t         div_rsp_i,
  input  logic                       pop_i,
  output logic                       res_valid_o,
  output logic [vbct_pkg::PCT_W-1:0] stable_o,
  output logic [vbct_pkg::PCT_W-1:0] relative_o,
  output logic [vbct_pkg::PCT_W-1:0] direct_o,
  output logic [vbct_pkg::GAP_W-1:0] gap_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  localparam logic signed [vbct_pkg::PCT_W+1:0] FULL_S = {2'b00, vbct_pkg::FULL_PERCENT};

  logic [1:0]                 state_q, state_d;
  vbct_pkg::item_t            item_q, item_d;
  logic [vbct_pkg::PCT_W-1:0] pct_q, pct_d;
  logic                       res_valid_q, res_valid_d;

  logic [vbct_pkg::PCT_W-1:0] stable_q, stable_d;
  logic [vbct_pkg::PCT_W-1:0] relative_q, relative_d;
  logic [vbct_pkg::PCT_W-1:0] previous_q, previous_d;
  logic                       skip_q, skip_d;
  logic                       track_q, track_d;
  logic [vbct_pkg::GAP_W-1:0] gap_q, gap_d;

  logic                              needs_div;
  logic                              apply;
  logic signed [vbct_pkg::PCT_W+1:0] rel_sum;
  logic signed [vbct_pkg::PCT_W+1:0] rel_pick;
  logic [vbct_pkg::PCT_W-1:0]        rel_clamp;
  logic [vbct_pkg::PCT_W-1:0]        rel_upd;
  logic signed [vbct_pkg::GAP_W-1:0] gap_new;

  assign needs_div = (q_item_i.op == vbct_pkg::OP_UPDATE || q_item_i.op == vbct_pkg::OP_DEFAULTS)
                     && !q_item_i.is_zero && !q_item_i.is_sat;
  assign apply     = (state_q == ST_APPLY) && (!res_valid_q || pop_i);

  always_comb begin
    state_d         = state_q;
    item_d          = item_q;
    pct_d           = pct_q;
    q_pop_o         = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.diff  = q_item_i.diff;
    div_req_o.den   = q_item_i.den;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          if (needs_div) begin
            div_req_o.start = 1'b1;
            state_d         = ST_WAIT;
          end else begin
            pct_d   = q_item_i.is_sat ? vbct_pkg::FULL_PERCENT : '0;
            state_d = ST_APPLY;
          end
        end
      end
      ST_WAIT: begin
        if (div_rsp_i.done) begin
          pct_d   = div_rsp_i.quo;
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Relative level for a periodic update, then the one-step stable move.
  always_comb begin
    rel_sum  = $signed({2'b00, relative_q}) + $signed({2'b00, pct_q})
               - $signed({2'b00, previous_q});
    rel_pick = track_q ? rel_sum : $signed({2'b00, pct_q});
    if (rel_pick > FULL_S || pct_q == vbct_pkg::FULL_PERCENT) begin
      rel_clamp = vbct_pkg::FULL_PERCENT;
    end else if (rel_pick < 0 || pct_q == '0) begin
      rel_clamp = '0;
    end else begin
      rel_clamp = rel_pick[vbct_pkg::PCT_W-1:0];
    end
    rel_upd = skip_q ? relative_q : rel_clamp;
    gap_new = $signed({1'b0, rel_upd}) - $signed({1'b0, stable_q});
  end

  always_comb begin
    stable_d   = stable_q;
    relative_d = relative_q;
    previous_d = previous_q;
    skip_d     = skip_q;
    track_d    = track_q;
    gap_d      = gap_q;
    if (apply) begin
      unique case (item_q.op)
        vbct_pkg::OP_UPDATE: begin
          relative_d = rel_upd;
          if (stable_q != '0 && gap_new < 0) begin
            stable_d = stable_q - vbct_pkg::PCT_W'(1);
          end else if (stable_q < vbct_pkg::FULL_PERCENT && gap_new > 0) begin
            stable_d = stable_q + vbct_pkg::PCT_W'(1);
          end
          previous_d = pct_q;
          gap_d      = gap_new;
          skip_d     = 1'b0;
        end
        vbct_pkg::OP_UNRELIABLE: begin
          skip_d  = 1'b1;
          track_d = item_q.mode;
        end
        vbct_pkg::OP_DEFAULTS: begin
          stable_d   = pct_q;
          relative_d = pct_q;
          previous_d = pct_q;
          skip_d     = 1'b0;
          track_d    = 1'b0;
        end
        vbct_pkg::OP_SUSPEND: begin
          skip_d = 1'b0;
        end
        default: begin
          skip_d = skip_q;
        end
      endcase
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (apply) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      stable_q    <= '0;
      relative_q  <= '0;
      previous_q  <= '0;
      skip_q      <= 1'b0;
      track_q     <= 1'b0;
      gap_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      stable_q    <= stable_d;
      relative_q  <= relative_d;
      previous_q  <= previous_d;
      skip_q      <= skip_d;
      track_q     <= track_d;
      gap_q       <= gap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pct_q  <= pct_d;
  end

  // The levels themselves form the result; they only change on a transfer
  // into a free result slot.
  assign res_valid_o = res_valid_q;
  assign stable_o    = stable_q;
  assign relative_o  = relative_q;
  assign direct_o    = previous_q;
  assign gap_o       = gap_q;

  `VBCT_ASSERT_IMP(a_start_from_idle, div_req_o.start, state_q == ST_IDLE && q_valid_i,
                   "divider started outside of an idle pop")
  `VBCT_ASSERT_IMP(a_done_in_wait, div_rsp_i.done, state_q == ST_WAIT,
                   "divider finished while no division was pending")
  `VBCT_ASSERT_NEXT(a_result_held, res_valid_q && !pop_i,
                    res_valid_q && $stable(stable_q) && $stable(relative_q)
                    && $stable(previous_q) && $stable(gap_q),
                    "waiting result changed before its transfer")
  `VBCT_ASSERT(a_levels_in_range, stable_q <= vbct_pkg::FULL_PERCENT
               && relative_q <= vbct_pkg::FULL_PERCENT && previous_q <= vbct_pkg::FULL_PERCENT,
               "capacity level above one hundred percent")

endmodule

/* rtl/voltage_battery_capacity_tracker_core.sv */
// Battery capacity tracker.
// Input channel: operation_i, voltage_sample_i and relative_mode_i are taken
// at a clock edge where push is high and full is low. A two-entry queue sits
// behind the input, so push can be accepted while a result is still waiting.
// Result channel: while empty is low the oldest result is on the capacity and
// gap outputs; it leaves at an edge where pop is high.
// Configuration: cfg_we_i writes cfg_wdata_i into empty voltage (index 0) or
// full voltage (index 1); write only while no item is in flight.
// A periodic update or load whose sample lies strictly between the two limits
// has its percent formed by a serial divider that produces one quotient bit
// per cycle; other items skip the divider. The back end takes the next item
// from the queue only after the current one has been applied.
// When the receiver stalls, the finished result stays on the outputs, the back
// end holds its next item, and full rises once the queue holds two items.
// Reset clears all levels, flags and the gap, empties the queue and loads
// 3400 and 4200 into the voltage limits.
module voltage_battery_capacity_tracker_core #(
  parameter int unsigned VOLTAGE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 operation_i,
  input  logic [VOLTAGE_BITS-1:0]    voltage_sample_i,
  input  logic                       relative_mode_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [vbct_pkg::PCT_W-1:0] stable_capacity_o,
  output logic [vbct_pkg::PCT_W-1:0] relative_capacity_o,
  output logic [vbct_pkg::PCT_W-1:0] voltage_capacity_o,
  output logic signed [vbct_pkg::GAP_W-1:0] relative_gap_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [vbct_pkg::CFG_W-1:0] cfg_wdata_i
);

  logic [vbct_pkg::CFG_W-1:0] empty_voltage_q;
  logic [vbct_pkg::CFG_W-1:0] full_voltage_q;

  logic               q_wr_en;
  vbct_pkg::item_t    q_wr_item;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  vbct_pkg::item_t    q_rd_item;
  vbct_pkg::div_req_t div_req;
  vbct_pkg::div_rsp_t div_rsp;
  logic               res_valid;
  logic [vbct_pkg::GAP_W-1:0] gap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_voltage_q <= 16'd3400;
      full_voltage_q  <= 16'd4200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vbct_pkg::CFG_EMPTY: empty_voltage_q <= cfg_wdata_i;
        vbct_pkg::CFG_FULL:  full_voltage_q  <= cfg_wdata_i;
        default: begin
          empty_voltage_q <= empty_voltage_q;
        end
      endcase
    end
  end

  vbct_front #(
    .VOLTAGE_BITS(VOLTAGE_BITS)
  ) u_front (
    .push_i          (push),
    .q_full_i        (q_full),
    .operation_i     (operation_i),
    .voltage_sample_i(voltage_sample_i),
    .relative_mode_i (relative_mode_i),
    .empty_voltage_i (empty_voltage_q),
    .full_voltage_i  (full_voltage_q),
    .wr_en_o         (q_wr_en),
    .item_o          (q_wr_item)
  );

  vbct_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (q_wr_en),
    .wr_item_i(q_wr_item),
    .rd_en_i  (q_pop),
    .rd_item_o(q_rd_item),
    .full_o   (q_full),
    .empty_o  (q_empty)
  );

  vbct_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  vbct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (!q_empty),
    .q_item_i   (q_rd_item),
    .q_pop_o    (q_pop),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .pop_i      (pop),
    .res_valid_o(res_valid),
    .stable_o   (stable_capacity_o),
    .relative_o (relative_capacity_o),
    .direct_o   (voltage_capacity_o),
    .gap_o      (gap)
  );

  assign full           = q_full;
  assign empty          = !res_valid;
  assign relative_gap_o = $signed(gap);

endmodule
